@@ design/rle_pkg.sv @@
package rle_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_EMIT  = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    TOK_NEED_BYTE  = 3'd0,
    TOK_ONE_PIX    = 3'd1,
    TOK_TWO_PIX    = 3'd2,
    TOK_RUN        = 3'd3,
    TOK_EOL_ALIGN  = 3'd4,
    TOK_EOL_SKIP   = 3'd5,
    TOK_BLANK_LINE = 3'd6
  } tok_kind_t;

  localparam int unsigned LINE_W   = 10;
  localparam int unsigned FRAME_W  = 18;
  localparam int unsigned RUN_W    = 15;
  localparam int unsigned CFG_W    = 18;

  localparam logic CFG_LINE_WIDTH   = 1'b0;
  localparam logic CFG_FRAME_PIXELS = 1'b1;

  localparam logic [LINE_W-1:0]  LINE_WIDTH_RST   = 10'd320;
  localparam logic [FRAME_W-1:0] FRAME_PIXELS_RST = 18'd76800;
  localparam logic [LINE_W-1:0]  LINE_WIDTH_MIN   = 10'd3;
  localparam logic [RUN_W-1:0]   RUN_CONTINUE     = 15'h7FFF;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] stream_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        token_kind;
    logic              pixel_white;
    logic [LINE_W-1:0] run_extra;
    logic              frame_done;
  } out_item_t;

endpackage

@@ design/rle_video_to_scanline_tokens.sv @@
// Channel   Signals                        Moves
// in        in_valid/in_ready/in_data      command: stream byte, emit, start
// out       out_valid/out_ready/out_data   one draw token per emit command
// cfg       cfg_we/cfg_index/cfg_wdata     line_width, frame_pixels
//
// One transaction per cycle on the input while in_ready is high; decoder state
// loads at the accept edge, and the token goes to the output register (or
// to a second output slot that absorbs one token while out_ready is low);
// in_ready drops only when both slots are full. Reset (sync, active low) clears
// the decoder state and loads the register defaults; no clearing pass.
module rle_video_to_scanline_tokens
  import rle_pkg::*;
#(
  parameter int unsigned MAX_LINE_WIDTH   = 1023,
  parameter int unsigned MAX_FRAME_PIXELS = 262143
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // line_width register is 10 bits, frame_pixels 18 bits: caps above that
  // never bind
  localparam int unsigned WMAX = (MAX_LINE_WIDTH > 1023) ? 1023 : MAX_LINE_WIDTH;
  localparam int unsigned FMAX = (MAX_FRAME_PIXELS > 262143) ? 262143 : MAX_FRAME_PIXELS;
  localparam logic [LINE_W-1:0]  WCAP = WMAX[LINE_W-1:0];
  localparam logic [FRAME_W-1:0] FCAP = FMAX[FRAME_W-1:0];
  localparam int unsigned PW = (MAX_FRAME_PIXELS < 2) ? 1 : $clog2(MAX_FRAME_PIXELS + 1);
  localparam int unsigned CW = (PW > FRAME_W) ? PW : FRAME_W;
  localparam logic [PW-1:0] PSAT = MAX_FRAME_PIXELS[PW-1:0];

  logic [LINE_W-1:0]  line_width_r;
  logic [FRAME_W-1:0] frame_pixels_r;

  logic [RUN_W-1:0]  run_left_r,     run_left_nxt;
  logic [6:0]        varint_low_r,   varint_low_nxt;
  logic              varint_half_r,  varint_half_nxt;
  logic              color_white_r,  color_white_nxt;
  logic              flip_pending_r, flip_pending_nxt;
  logic [LINE_W-1:0] line_pos_r,     line_pos_nxt;
  logic              word_parity_r,  word_parity_nxt;
  logic [PW-1:0]     pixels_done_r,  pixels_done_nxt;

  out_item_t out_r, skid_r, res;
  logic      out_valid_r, skid_valid_r;
  logic      has_res;

  logic              in_fire, out_fire;
  logic [LINE_W-1:0] width_clip, width_eff;
  logic [FRAME_W-1:0] frame_eff;
  logic [LINE_W-1:0] room, cut;
  logic [CW:0]       sum;
  logic [RUN_W-1:0]  load_len;
  logic              load_en;

  assign in_fire   = in_valid & in_ready;
  assign out_fire  = out_valid_r & out_ready;
  assign in_ready  = ~skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    width_clip = (line_width_r > WCAP) ? WCAP : line_width_r;
    width_eff  = (width_clip < LINE_WIDTH_MIN) ? LINE_WIDTH_MIN : width_clip;
    frame_eff  = (frame_pixels_r > FCAP) ? FCAP : frame_pixels_r;
    room       = width_eff - line_pos_r;
    cut        = (run_left_r > RUN_W'(room)) ? room : run_left_r[LINE_W-1:0];
    sum        = (CW + 1)'(pixels_done_r) + (CW + 1)'(cut);
  end

  always_comb begin
    run_left_nxt     = run_left_r;
    varint_low_nxt   = varint_low_r;
    varint_half_nxt  = varint_half_r;
    color_white_nxt  = color_white_r;
    flip_pending_nxt = flip_pending_r;
    line_pos_nxt     = line_pos_r;
    word_parity_nxt  = word_parity_r;
    pixels_done_nxt  = pixels_done_r;
    has_res          = 1'b0;
    res              = '0;
    load_en          = 1'b0;
    load_len         = '0;

    unique case (in_data.cmd)
      CMD_START: begin
        run_left_nxt     = '0;
        varint_low_nxt   = '0;
        varint_half_nxt  = 1'b0;
        color_white_nxt  = 1'b0;
        flip_pending_nxt = 1'b0;
        line_pos_nxt     = '0;
        word_parity_nxt  = 1'b0;
        pixels_done_nxt  = '0;
      end
      CMD_BYTE: begin
        // bytes arriving while a run is pending are dropped
        if (run_left_r == '0) begin
          if (varint_half_r) begin
            varint_half_nxt = 1'b0;
            load_en         = 1'b1;
            load_len        = {in_data.stream_byte, varint_low_r};
          end else if (in_data.stream_byte[7]) begin
            varint_low_nxt  = in_data.stream_byte[6:0];
            varint_half_nxt = 1'b1;
          end else begin
            load_en  = 1'b1;
            load_len = RUN_W'(in_data.stream_byte);
          end
        end
      end
      CMD_EMIT: begin
        has_res = 1'b1;
        priority if (line_pos_r >= width_eff) begin
          res.token_kind  = word_parity_r ? TOK_EOL_ALIGN : TOK_EOL_SKIP;
          line_pos_nxt    = '0;
          word_parity_nxt = 1'b0;
        end else if (CW'(pixels_done_r) >= CW'(frame_eff)) begin
          res.token_kind  = TOK_BLANK_LINE;
          res.run_extra   = width_eff - LINE_WIDTH_MIN;
          line_pos_nxt    = '0;
          word_parity_nxt = 1'b0;
        end else if (run_left_r == '0) begin
          res.token_kind = TOK_NEED_BYTE;
        end else begin
          run_left_nxt    = run_left_r - RUN_W'(cut);
          line_pos_nxt    = line_pos_r + cut;
          pixels_done_nxt = (sum > (CW + 1)'(MAX_FRAME_PIXELS)) ? PSAT : sum[PW-1:0];
          res.pixel_white = color_white_r;
          if (cut == LINE_W'(1)) begin
            res.token_kind = TOK_ONE_PIX;
          end else if (cut == LINE_W'(2)) begin
            res.token_kind  = TOK_TWO_PIX;
            word_parity_nxt = ~word_parity_r;
          end else begin
            res.token_kind  = TOK_RUN;
            res.run_extra   = cut - LINE_WIDTH_MIN;
            word_parity_nxt = ~word_parity_r;
          end
        end
        res.frame_done = CW'(pixels_done_nxt) >= CW'(frame_eff);
      end
      default: ;
    endcase

    // a maximal run keeps the current color for the next one
    if (load_en) begin
      if (flip_pending_r) color_white_nxt = ~color_white_r;
      run_left_nxt     = load_len;
      flip_pending_nxt = (load_len != RUN_CONTINUE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      frame_pixels_r <= FRAME_PIXELS_RST;
      run_left_r     <= '0;
      varint_low_r   <= '0;
      varint_half_r  <= 1'b0;
      color_white_r  <= 1'b0;
      flip_pending_r <= 1'b0;
      line_pos_r     <= '0;
      word_parity_r  <= 1'b0;
      pixels_done_r  <= '0;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LINE_WIDTH:   line_width_r   <= cfg_wdata[LINE_W-1:0];
          CFG_FRAME_PIXELS: frame_pixels_r <= cfg_wdata[FRAME_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        run_left_r     <= run_left_nxt;
        varint_low_r   <= varint_low_nxt;
        varint_half_r  <= varint_half_nxt;
        color_white_r  <= color_white_nxt;
        flip_pending_r <= flip_pending_nxt;
        line_pos_r     <= line_pos_nxt;
        word_parity_r  <= word_parity_nxt;
        pixels_done_r  <= pixels_done_nxt;
      end
      // skid slot full implies in_ready low, so no new token competes
      if (!out_valid_r || out_fire) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_fire & has_res;
        end
      end else if (in_fire && has_res) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_fire && has_res) begin
      skid_r <= res;
    end
  end

endmodule
